[design/edfrgs_pkg.sv]
// edfrgs_pkg: shared constants, types and helpers of the edf resource grant scheduler
// no dependencies; imported by every module of the block
package edfrgs_pkg;

  // table geometry
  localparam int NUM_PROCESSES          = 8;
  localparam int NUM_RESOURCES          = 4;
  localparam int INSTANCES_PER_RESOURCE = 8;

  // field widths
  localparam int PROC_W     = 3;
  localparam int RES_W      = 2;
  localparam int INST_IDX_W = 3;
  localparam int CNT_W      = 4;
  localparam int DL_W       = 16;
  localparam int FREE_W     = $clog2(INSTANCES_PER_RESOURCE + 1);

  localparam logic [DL_W-1:0] CEILING_RESET = 16'd1000;

  // function codes of an input word
  localparam logic [1:0] FUNC_LOAD    = 2'd0;
  localparam logic [1:0] FUNC_DECIDE  = 2'd1;
  localparam logic [1:0] FUNC_RELEASE = 2'd2;

  typedef logic [INSTANCES_PER_RESOURCE-1:0] inst_mask_t;

  // one request row: per-resource counts and the deadline
  typedef struct packed {
    logic [NUM_RESOURCES-1:0][CNT_W-1:0] counts;
    logic [DL_W-1:0]                     deadline;
  } row_t;

  // release of one instance
  typedef struct packed {
    logic                  en;
    logic [RES_W-1:0]      res;
    logic [INST_IDX_W-1:0] inst;
  } release_t;

  // claim of the lowest free instances of one resource
  typedef struct packed {
    logic             en;
    logic [RES_W-1:0] res;
    logic [CNT_W-1:0] need;
  } claim_t;

  typedef logic [NUM_RESOURCES-1:0][FREE_W-1:0] free_cnt_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ACK,
    ST_SCAN,
    ST_SCAN_END,
    ST_PICK,
    ST_GRANT
  } state_t;

  // number of set bits in an instance map
  function automatic logic [FREE_W-1:0] count_ones(inst_mask_t v);
    logic [FREE_W-1:0] n;
    n = '0;
    for (int i = 0; i < INSTANCES_PER_RESOURCE; i++) begin
      n = n + FREE_W'(v[i]);
    end
    return n;
  endfunction

endpackage

[design/edfrgs_row_store.sv]
// edfrgs_row_store: request table memory, one row per process, registered read
// depends on edfrgs_pkg
module edfrgs_row_store
  import edfrgs_pkg::*;
(
  input  logic              clk,
  input  logic              we,
  input  logic [PROC_W-1:0] waddr,
  input  row_t              wdata,
  input  logic [PROC_W-1:0] raddr,
  output row_t              rdata
);

  row_t mem [NUM_PROCESSES];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[design/edfrgs_free_map.sv]
// edfrgs_free_map: free-instance bitmaps, free counts and lowest-first claim logic
// depends on edfrgs_pkg
module edfrgs_free_map
  import edfrgs_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  release_t   rel,
  input  claim_t     claim,
  output free_cnt_t  free_cnt,
  output inst_mask_t got
);

  inst_mask_t map [NUM_RESOURCES];

  // pick the lowest-numbered free instances, one bit a step
  always_comb begin
    logic [CNT_W-1:0] left;
    inst_mask_t       sel;
    left = claim.need;
    sel  = map[claim.res];
    got  = '0;
    for (int i = 0; i < INSTANCES_PER_RESOURCE; i++) begin
      if (sel[i] && (left != '0)) begin
        got[i] = 1'b1;
        left   = left - CNT_W'(1);
      end
    end
  end

  // free counts per resource
  always_comb begin
    for (int r = 0; r < NUM_RESOURCES; r++) begin
      free_cnt[r] = count_ones(map[r]);
    end
  end

  // bitmap update: releases set a bit, claims clear the granted bits
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int r = 0; r < NUM_RESOURCES; r++) begin
        map[r] <= '0;
      end
    end else begin
      if (rel.en) begin
        map[rel.res][rel.inst] <= 1'b1;
      end
      if (claim.en) begin
        map[claim.res] <= map[claim.res] & ~got;
      end
    end
  end

endmodule

[design/edfrgs_row_check.sv]
// edfrgs_row_check: shared compare unit, tests one row per cycle against free counts
// and the best deadline so far; depends on edfrgs_pkg
module edfrgs_row_check
  import edfrgs_pkg::*;
(
  input  row_t            row,
  input  logic            pending,
  input  free_cnt_t       free_cnt,
  input  logic [DL_W-1:0] best_dl,
  output logic            take
);

  logic fits;

  // every count must fit the free instances of its resource
  always_comb begin
    fits = 1'b1;
    for (int r = 0; r < NUM_RESOURCES; r++) begin
      if (row.counts[r] > free_cnt[r]) begin
        fits = 1'b0;
      end
    end
  end

  // strictly earlier deadline keeps the lowest index on ties
  assign take = pending && fits && (row.deadline < best_dl);

endmodule

[design/edfrgs_resource_grant_scheduler_unit.sv]
// edf_resource_grant_scheduler_unit: top level, sequencer, pending bits and result register
// depends on edfrgs_pkg, edfrgs_row_store, edfrgs_free_map, edfrgs_row_check

// Earliest-deadline-first grant scheduler. A load word writes one request row,
// a release word frees one resource instance, and both go through ST_ACK, which
// loads one acknowledge word into the output register once it is free and returns
// to idle, ready again. A decide word scans the eight rows through one shared compare
// unit, one row per cycle out of the request memory, lets the last compare settle in
// ST_SCAN_END, fetches the winner in ST_PICK and hands out one word per resource (four)
// in ST_GRANT while the result side takes them, or one word with grant_valid low when
// no row is eligible. The block takes one word at a time; a finished result sits in
// the output register while the next word is accepted. deadline_ceiling is written
// through the cfg port, always ready, by the user only while idle; the block does not enforce it.
module edf_resource_grant_scheduler_unit
  import edfrgs_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  // configuration
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [DL_W-1:0]       cfg_data,
  // input channel
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [1:0]            func,
  input  logic [PROC_W-1:0]     process_index,
  input  logic [CNT_W-1:0]      request_res0,
  input  logic [CNT_W-1:0]      request_res1,
  input  logic [CNT_W-1:0]      request_res2,
  input  logic [CNT_W-1:0]      request_res3,
  input  logic [DL_W-1:0]       request_deadline,
  input  logic                  row_valid,
  input  logic [RES_W-1:0]      release_resource,
  input  logic [INST_IDX_W-1:0] release_instance,
  // output channel
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  grant_valid,
  output logic [PROC_W-1:0]     granted_process,
  output logic [RES_W-1:0]      granted_resource,
  output inst_mask_t            instance_mask,
  output logic                  last
);

  state_t            state, state_next;
  logic [DL_W-1:0]   ceiling;
  logic [PROC_W-1:0] ptr;
  logic              chk_vld;
  logic [PROC_W-1:0] chk_idx;
  logic [PROC_W-1:0] best_idx;
  logic [DL_W-1:0]   best_dl;
  logic              found;
  logic [RES_W-1:0]  gres;
  logic              pending [NUM_PROCESSES];

  logic              out_free;
  logic              out_load;
  logic              out_gv;
  logic              out_last;
  logic              mem_we;
  logic [PROC_W-1:0] rd_addr;
  logic              scan_start;
  logic              ptr_inc;
  row_t              w_row;
  row_t              rd_row;
  release_t          rel;
  claim_t            claim;
  free_cnt_t         free_cnt;
  inst_mask_t        got;
  logic              take;

  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid || out_ready;

  // row written by a load
  always_comb begin
    w_row.counts[0] = request_res0;
    w_row.counts[1] = request_res1;
    w_row.counts[2] = request_res2;
    w_row.counts[3] = request_res3;
    w_row.deadline  = request_deadline;
  end

  edfrgs_row_store u_row_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (process_index),
    .wdata (w_row),
    .raddr (rd_addr),
    .rdata (rd_row)
  );

  edfrgs_free_map u_free_map (
    .clk      (clk),
    .rst      (rst),
    .rel      (rel),
    .claim    (claim),
    .free_cnt (free_cnt),
    .got      (got)
  );

  edfrgs_row_check u_row_check (
    .row      (rd_row),
    .pending  (pending[chk_idx]),
    .free_cnt (free_cnt),
    .best_dl  (best_dl),
    .take     (take)
  );

  // sequencer: next state and control
  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    rd_addr    = ptr;
    mem_we     = 1'b0;
    rel        = '0;
    claim      = '0;
    out_load   = 1'b0;
    out_gv     = 1'b0;
    out_last   = 1'b1;
    scan_start = 1'b0;
    ptr_inc    = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          unique case (func)
            FUNC_LOAD: begin
              mem_we     = 1'b1;
              state_next = ST_ACK;
            end
            FUNC_DECIDE: begin
              scan_start = 1'b1;
              state_next = ST_SCAN;
            end
            FUNC_RELEASE: begin
              rel.en     = 1'b1;
              rel.res    = release_resource;
              rel.inst   = release_instance;
              state_next = ST_ACK;
            end
            default: begin
              state_next = ST_ACK;
            end
          endcase
        end
      end
      ST_ACK: begin
        if (out_free) begin
          out_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      ST_SCAN: begin
        ptr_inc = 1'b1;
        if (ptr == PROC_W'(NUM_PROCESSES - 1)) begin
          state_next = ST_SCAN_END;
        end
      end
      ST_SCAN_END: begin
        state_next = ST_PICK;
      end
      ST_PICK: begin
        rd_addr = best_idx;
        if (found) begin
          state_next = ST_GRANT;
        end else if (out_free) begin
          out_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      ST_GRANT: begin
        rd_addr = best_idx;
        if (out_free) begin
          claim.en   = 1'b1;
          claim.res  = gres;
          claim.need = rd_row.counts[gres];
          out_load   = 1'b1;
          out_gv     = 1'b1;
          out_last   = (gres == RES_W'(NUM_RESOURCES - 1));
          if (out_last) begin
            state_next = ST_IDLE;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      ceiling   <= CEILING_RESET;
      out_valid <= 1'b0;
      chk_vld   <= 1'b0;
      found     <= 1'b0;
      ptr       <= '0;
      gres      <= '0;
      for (int p = 0; p < NUM_PROCESSES; p++) begin
        pending[p] <= 1'b0;
      end
    end else begin
      state   <= state_next;
      chk_vld <= (state == ST_SCAN);
      if (cfg_valid) begin
        ceiling <= cfg_data;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (scan_start) begin
        ptr   <= '0;
        found <= 1'b0;
        gres  <= '0;
      end else if (ptr_inc) begin
        ptr <= ptr + PROC_W'(1);
      end
      if (chk_vld && take) begin
        found <= 1'b1;
      end
      if (mem_we) begin
        pending[process_index] <= row_valid;
      end
      if (claim.en) begin
        gres <= gres + RES_W'(1);
        if (out_last) begin
          pending[best_idx] <= 1'b0;
        end
      end
    end
  end

  // scan datapath and result payload
  always_ff @(posedge clk) begin
    chk_idx <= ptr;
    if (scan_start) begin
      best_dl <= ceiling;
    end else if (chk_vld && take) begin
      best_dl  <= rd_row.deadline;
      best_idx <= chk_idx;
    end
    if (out_load) begin
      grant_valid      <= out_gv;
      granted_process  <= out_gv ? best_idx : '0;
      granted_resource <= out_gv ? gres : '0;
      instance_mask    <= out_gv ? got : '0;
      last             <= out_last;
    end
  end

  // a claim hands out exactly the requested number of instances
  a_claim_count: assert property (@(posedge clk) disable iff (rst)
    claim.en |-> ($countones(got) == 32'(claim.need)))
    else $error("claim mask does not match requested count");

  // a winner always lies strictly below the ceiling
  a_winner_below_ceiling: assert property (@(posedge clk) disable iff (rst)
    (state == ST_PICK && found) |-> (best_dl < ceiling))
    else $error("selected deadline not below ceiling");

  // a word without a grant is a lone final word with an empty mask
  a_no_grant_word: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !grant_valid) |-> (last && instance_mask == '0))
    else $error("non-grant word carries data");

endmodule
